[src/tked_pkg.sv]
package tked_pkg;

	localparam int unsigned ByteW = 8;

	// Named key ids
	localparam logic [ByteW-1:0] KeyHome  = 8'd0;
	localparam logic [ByteW-1:0] KeyUp    = 8'd1;
	localparam logic [ByteW-1:0] KeyPgUp  = 8'd2;
	localparam logic [ByteW-1:0] KeyLeft  = 8'd3;
	localparam logic [ByteW-1:0] KeyRight = 8'd4;
	localparam logic [ByteW-1:0] KeyEnd   = 8'd5;
	localparam logic [ByteW-1:0] KeyDown  = 8'd6;
	localparam logic [ByteW-1:0] KeyPgDn  = 8'd7;
	localparam logic [ByteW-1:0] KeyDel   = 8'd8;

	// Special byte codes
	localparam logic [ByteW-1:0] ChrNul   = 8'd0;
	localparam logic [ByteW-1:0] ChrEsc   = 8'd27;
	localparam logic [ByteW-1:0] ChrLBrk  = 8'h5B; // '['
	localparam logic [ByteW-1:0] ChrO     = 8'h4F; // 'O'
	localparam logic [ByteW-1:0] ChrTilde = 8'h7E; // '~'
	localparam logic [ByteW-1:0] ChrSemi  = 8'h3B; // ';'
	localparam logic [ByteW-1:0] ChrZero  = 8'h30; // '0'
	localparam logic [ByteW-1:0] ChrNine  = 8'h39; // '9'
	localparam logic [ByteW-1:0] ChrA     = 8'h41;
	localparam logic [ByteW-1:0] ChrB     = 8'h42;
	localparam logic [ByteW-1:0] ChrC     = 8'h43;
	localparam logic [ByteW-1:0] ChrD     = 8'h44;
	localparam logic [ByteW-1:0] ChrF     = 8'h46;
	localparam logic [ByteW-1:0] ChrH     = 8'h48;

	// DOS scan codes
	localparam logic [ByteW-1:0] ScHome  = 8'd71;
	localparam logic [ByteW-1:0] ScUp    = 8'd72;
	localparam logic [ByteW-1:0] ScPgUp  = 8'd73;
	localparam logic [ByteW-1:0] ScLeft  = 8'd75;
	localparam logic [ByteW-1:0] ScRight = 8'd77;
	localparam logic [ByteW-1:0] ScEnd   = 8'd79;
	localparam logic [ByteW-1:0] ScDown  = 8'd80;
	localparam logic [ByteW-1:0] ScPgDn  = 8'd81;
	localparam logic [ByteW-1:0] ScDel   = 8'd83;

	// Decimal codes closed by '~'
	localparam logic [ByteW-1:0] CodeHome    = 8'd1;
	localparam logic [ByteW-1:0] CodeDel     = 8'd3;
	localparam logic [ByteW-1:0] CodeEnd     = 8'd4;
	localparam logic [ByteW-1:0] CodePgUp    = 8'd5;
	localparam logic [ByteW-1:0] CodePgDn    = 8'd6;
	localparam logic [ByteW-1:0] CodeHomeAlt = 8'd7;
	localparam logic [ByteW-1:0] CodeEndAlt  = 8'd8;

	localparam logic [ByteW-1:0] EscTimeoutReset = 8'd2;

	typedef struct packed {
		logic             named;
		logic [ByteW-1:0] value;
	} key_t;

	// Decoder result for one item
	typedef struct packed {
		logic valid;
		key_t key;
	} dec_res_t;

endpackage

[src/tked_item_if.sv]
interface tked_item_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source (output valid, kind, data_byte, input ready);
	modport sink (input valid, kind, data_byte, output ready);
endinterface

[src/tked_key_if.sv]
interface tked_key_if;
	logic       valid;
	logic       ready;
	logic       key_named;
	logic [7:0] key_value;

	modport source (output valid, key_named, key_value, input ready);
	modport sink (input valid, key_named, key_value, output ready);
endinterface

[src/tked_decode.sv]
module tked_decode
	import tked_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             kind,
	input  logic [ByteW-1:0] data_byte,
	input  logic [ByteW-1:0] timeout,
	output dec_res_t         res
);

	typedef enum logic [2:0] {
		M_IDLE,
		M_DOS,
		M_ESC,
		M_INTRO,
		M_NUMBER,
		M_PARAMS
	} mode_t;

	mode_t            mode_q, mode_d;
	logic [ByteW-1:0] wait_q, wait_d;
	logic [ByteW-1:0] code_q, code_d;

	logic             is_digit;
	logic [3:0]       digit;
	logic [ByteW:0]   wait_inc;
	logic [11:0]      code_mul;

	// DOS scan code to key
	function automatic key_t dos_map(input logic [ByteW-1:0] sc);
		key_t k;
		k.named = 1'b1;
		unique case (sc)
			ScHome:  k.value = KeyHome;
			ScUp:    k.value = KeyUp;
			ScPgUp:  k.value = KeyPgUp;
			ScLeft:  k.value = KeyLeft;
			ScRight: k.value = KeyRight;
			ScEnd:   k.value = KeyEnd;
			ScDown:  k.value = KeyDown;
			ScPgDn:  k.value = KeyPgDn;
			ScDel:   k.value = KeyDel;
			default: begin
				k.named = 1'b0;
				k.value = sc;
			end
		endcase
		return k;
	endfunction

	// Final byte of a numeric sequence
	function automatic key_t code_final(input logic [ByteW-1:0] b,
			input logic [ByteW-1:0] code);
		key_t k;
		k.named = 1'b1;
		k.value = b;
		if (b == ChrTilde && (code == CodeHome || code == CodeHomeAlt)) begin
			k.value = KeyHome;
		end else if (b == ChrTilde && (code == CodeEnd || code == CodeEndAlt)) begin
			k.value = KeyEnd;
		end else if (b == ChrTilde && code == CodePgUp) begin
			k.value = KeyPgUp;
		end else if (b == ChrTilde && code == CodePgDn) begin
			k.value = KeyPgDn;
		end else if (b == ChrTilde && code == CodeDel) begin
			k.value = KeyDel;
		end else if (b == ChrH) begin
			k.value = KeyHome;
		end else if (b == ChrF) begin
			k.value = KeyEnd;
		end else begin
			k.named = 1'b0;
		end
		return k;
	endfunction

	assign is_digit = (data_byte >= ChrZero) && (data_byte <= ChrNine);
	assign digit    = 4'(data_byte - ChrZero);
	assign wait_inc = {1'b0, wait_q} + 9'd1;
	// code * 10 + digit, as shifts and adds
	assign code_mul = {1'b0, code_q, 3'b000} + {3'b000, code_q, 1'b0} + {8'h00, digit};

	// Next state and result
	always_comb begin
		mode_d    = mode_q;
		wait_d    = wait_q;
		code_d    = code_q;
		res.valid = 1'b0;
		res.key   = '{named: 1'b0, value: data_byte};
		if (kind) begin
			// timer tick only matters while waiting after ESC
			if (mode_q == M_ESC) begin
				if (wait_inc >= {1'b0, timeout}) begin
					res.valid = 1'b1;
					res.key   = '{named: 1'b0, value: ChrEsc};
					mode_d    = M_IDLE;
				end else begin
					wait_d = wait_inc[ByteW-1:0];
				end
			end
		end else begin
			unique case (mode_q)
				M_IDLE: begin
					if (data_byte == ChrNul) begin
						mode_d = M_DOS;
					end else if (data_byte == ChrEsc) begin
						mode_d = M_ESC;
						wait_d = '0;
					end else begin
						res.valid = 1'b1;
					end
				end
				M_DOS: begin
					res.valid = 1'b1;
					res.key   = dos_map(data_byte);
					mode_d    = M_IDLE;
				end
				M_ESC: begin
					if (data_byte == ChrLBrk || data_byte == ChrO) begin
						mode_d = M_INTRO;
					end else begin
						res.valid = 1'b1;
						mode_d    = M_IDLE;
					end
				end
				M_INTRO: begin
					res.valid = 1'b1;
					res.key.named = 1'b1;
					mode_d    = M_IDLE;
					case (data_byte)
						ChrA:    res.key.value = KeyUp;
						ChrB:    res.key.value = KeyDown;
						ChrC:    res.key.value = KeyRight;
						ChrD:    res.key.value = KeyLeft;
						ChrH:    res.key.value = KeyHome;
						ChrF:    res.key.value = KeyEnd;
						default: begin
							res.key.named = 1'b0;
							if (is_digit) begin
								res.valid = 1'b0;
								code_d    = {4'h0, digit};
								mode_d    = M_NUMBER;
							end
						end
					endcase
				end
				M_NUMBER: begin
					if (is_digit) begin
						code_d = (code_mul > 12'd255) ? 8'hFF : code_mul[ByteW-1:0];
					end else if (data_byte == ChrSemi) begin
						mode_d = M_PARAMS;
					end else begin
						res.valid = 1'b1;
						res.key   = code_final(data_byte, code_q);
						mode_d    = M_IDLE;
					end
				end
				M_PARAMS: begin
					if (!(is_digit || data_byte == ChrSemi)) begin
						res.valid = 1'b1;
						res.key   = code_final(data_byte, code_q);
						mode_d    = M_IDLE;
					end
				end
				default: mode_d = M_IDLE;
			endcase
		end
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			wait_q <= '0;
			code_q <= '0;
		end else if (advance) begin
			mode_q <= mode_d;
			wait_q <= wait_d;
			code_q <= code_d;
		end
	end

endmodule

[src/terminal_key_escape_decoder.sv]
// Terminal key decoder: each transfer on item is either a received key byte
// (kind 0) or one elapsed timer tick (kind 1), and gives zero or one transfer
// on key. DOS two-byte codes and ESC '[' / ESC 'O' sequences map to named
// navigation keys (key_named 1, key_value 0..8); everything else comes out as
// the raw byte. A lone ESC is reported after esc_timeout_ticks ticks (reset 2,
// zero acts as one). One item is taken per cycle while the pipeline does not
// stall: it is held in the input register, decoded, and its key lands in the
// output register. The pipeline stalls only while the output register holds
// a key that key.ready has not taken. Write esc_timeout_ticks through
// cfg_we/cfg_wdata only while the block is idle.
module terminal_key_escape_decoder
	import tked_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [ByteW-1:0] cfg_wdata,
	tked_item_if.sink        item,
	tked_key_if.source       key
);

	logic             item_valid_s1;
	logic             kind_s1;
	logic [ByteW-1:0] byte_s1;
	logic [ByteW-1:0] timeout_q;
	logic             key_valid_q;
	key_t             key_q;
	logic             stall;
	logic             advance;
	dec_res_t         res;

	assign stall      = key_valid_q && !key.ready;
	assign advance    = item_valid_s1 && !stall;
	assign item.ready = !item_valid_s1 || !stall;

	assign key.valid     = key_valid_q;
	assign key.key_named = key_q.named;
	assign key.key_value = key_q.value;

	// Timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= EscTimeoutReset;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item.ready) begin
			item_valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			kind_s1 <= item.kind;
			byte_s1 <= item.data_byte;
		end
	end

	tked_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.kind      (kind_s1),
		.data_byte (byte_s1),
		.timeout   (timeout_q),
		.res       (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_valid_q <= 1'b0;
		end else if (!stall) begin
			key_valid_q <= advance && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			key_q <= res.key;
		end
	end

endmodule

[tb/sv/terminal_key_escape_decoder_tb.sv]
`timescale 1ns / 100ps

module terminal_key_escape_decoder_tb;
	import tked_pkg::*;

	localparam logic KindByte = 1'b0;
	localparam logic KindTick = 1'b1;

	localparam int PhaseItems  = 225;
	localparam int IdleLimit   = 1000;
	localparam int DrainCycles = 4;
	localparam int MaxReported = 10;

	typedef enum logic [2:0] {
		ModeIdle, ModeDos, ModeEsc, ModeIntro, ModeNumber, ModeParams
	} dec_mode_e;

	typedef enum int {RxOpen, RxCoin, RxComb, RxChoke} rx_mode_e;

	typedef struct {
		logic       kind;
		logic [7:0] data;
		bit         typed;
		key_t       key;
	} dir_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [ByteW-1:0] cfg_wdata;

	tked_item_if item_ch ();
	tked_key_if  key_ch ();

	terminal_key_escape_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.key       (key_ch)
	);

	// Shadow decoder state
	dec_mode_e  pm_mode;
	logic [7:0] pm_ticks;
	logic [7:0] pm_code;
	logic [7:0] pm_timeout;

	key_t key_q [$];

	int       fed_items;
	int       burst_left;
	int       keys_seen;
	int       named_seen;
	int       esc_timeouts;
	int       mismatches;
	int       idle_cycles;
	int       rx_cycle;
	rx_mode_e rx_mode;
	key_t     got_key;
	key_t     want_key;

	logic [7:0] dos_codes [9] = '{ScHome, ScUp, ScPgUp, ScLeft, ScRight,
		ScEnd, ScDown, ScPgDn, ScDel};
	logic [7:0] intro_finals [6] = '{ChrA, ChrB, ChrC, ChrD, ChrH, ChrF};

	dir_row_t dir_rows [$];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit is_digit(input logic [7:0] b);
		return b >= ChrZero && b <= ChrNine;
	endfunction

	// Final byte after a decimal code
	function automatic key_t code_final_key(input logic [7:0] b);
		key_t k;
		k.named = 1'b1;
		k.value = b;
		if (b == ChrTilde && (pm_code == CodeHome || pm_code == CodeHomeAlt))
			k.value = KeyHome;
		else if (b == ChrTilde && (pm_code == CodeEnd || pm_code == CodeEndAlt))
			k.value = KeyEnd;
		else if (b == ChrTilde && pm_code == CodePgUp)
			k.value = KeyPgUp;
		else if (b == ChrTilde && pm_code == CodePgDn)
			k.value = KeyPgDn;
		else if (b == ChrTilde && pm_code == CodeDel)
			k.value = KeyDel;
		else if (b == ChrH)
			k.value = KeyHome;
		else if (b == ChrF)
			k.value = KeyEnd;
		else
			k.named = 1'b0;
		return k;
	endfunction

	// Advance the shadow decoder by one item; returns 1 when a key comes out
	function automatic bit predict_key(input logic kind, input logic [7:0] b,
		output key_t k);
		int v;
		bit hit;
		k = '{1'b0, b};
		hit = 1'b0;
		if (kind == KindTick) begin
			if (pm_mode == ModeEsc) begin
				if (int'(pm_ticks) + 1 >= int'(pm_timeout)) begin
					k = '{1'b0, ChrEsc};
					hit = 1'b1;
					esc_timeouts++;
				end else begin
					pm_ticks = pm_ticks + 8'd1;
				end
			end
		end else begin
			case (pm_mode)
				ModeIdle: begin
					if (b == ChrNul) begin
						pm_mode = ModeDos;
					end else if (b == ChrEsc) begin
						pm_mode = ModeEsc;
						pm_ticks = 8'd0;
					end else begin
						hit = 1'b1;
					end
				end
				ModeDos: begin
					hit = 1'b1;
					k.named = 1'b1;
					case (b)
						ScHome:  k.value = KeyHome;
						ScUp:    k.value = KeyUp;
						ScPgUp:  k.value = KeyPgUp;
						ScLeft:  k.value = KeyLeft;
						ScRight: k.value = KeyRight;
						ScEnd:   k.value = KeyEnd;
						ScDown:  k.value = KeyDown;
						ScPgDn:  k.value = KeyPgDn;
						ScDel:   k.value = KeyDel;
						default: k.named = 1'b0;
					endcase
				end
				ModeEsc: begin
					if (b == ChrLBrk || b == ChrO)
						pm_mode = ModeIntro;
					else
						hit = 1'b1;
				end
				ModeIntro: begin
					hit = 1'b1;
					k.named = 1'b1;
					case (b)
						ChrA: k.value = KeyUp;
						ChrB: k.value = KeyDown;
						ChrC: k.value = KeyRight;
						ChrD: k.value = KeyLeft;
						ChrH: k.value = KeyHome;
						ChrF: k.value = KeyEnd;
						default: begin
							k.named = 1'b0;
							if (is_digit(b)) begin
								hit = 1'b0;
								pm_code = b - ChrZero;
								pm_mode = ModeNumber;
							end
						end
					endcase
				end
				ModeNumber: begin
					if (is_digit(b)) begin
						// code saturates at 255
						v = int'(pm_code) * 10 + int'(b) - int'(ChrZero);
						pm_code = (v > 255) ? 8'd255 : v[7:0];
					end else if (b == ChrSemi) begin
						pm_mode = ModeParams;
					end else begin
						k = code_final_key(b);
						hit = 1'b1;
					end
				end
				ModeParams: begin
					if (!(is_digit(b) || b == ChrSemi)) begin
						k = code_final_key(b);
						hit = 1'b1;
					end
				end
				default: pm_mode = ModeIdle;
			endcase
		end
		if (hit)
			pm_mode = ModeIdle;
		return hit;
	endfunction

	// Sender: bursts of random length, random gaps between them
	task automatic send_item(input logic kind, input logic [7:0] b,
		input bit typed = 1'b0, input key_t typed_key = '0);
		int gap;
		key_t k;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		// ticks outside the ESC wait are ignored by the block
		if (!(kind == KindTick && pm_mode != ModeEsc))
			fed_items++;
		item_ch.valid     <= 1'b1;
		item_ch.kind      <= kind;
		item_ch.data_byte <= b;
		do @(posedge clk); while (!item_ch.ready);
		if (predict_key(kind, b, k))
			key_q.push_back(typed ? typed_key : k);
	endtask

	// Byte with an occasional stray tick in front
	task automatic send_byte(input logic [7:0] b);
		if ($urandom_range(0, 15) == 0)
			send_item(KindTick, 8'($urandom_range(0, 255)));
		send_item(KindByte, b);
	endtask

	// Timeout write, only once the pipeline has drained
	task automatic write_timeout(input logic [7:0] v);
		while (key_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		pm_timeout = v;
	endtask

	// One random key sequence, mostly well formed
	task automatic play_sequence();
		int pick;
		int n;
		int eff;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			send_byte(8'($urandom_range(0, 255)));
		end else if (pick < 30) begin
			send_byte(ChrNul);
			if ($urandom_range(0, 1) == 0)
				send_byte(dos_codes[4'($urandom_range(0, 8))]);
			else
				send_byte(8'($urandom_range(0, 255)));
		end else if (pick < 50) begin
			send_byte(ChrEsc);
			send_byte(($urandom_range(0, 1) == 0) ? ChrLBrk : ChrO);
			if ($urandom_range(0, 3) != 0)
				send_byte(intro_finals[3'($urandom_range(0, 5))]);
			else
				send_byte(8'($urandom_range(0, 255)));
		end else if (pick < 75) begin
			send_byte(ChrEsc);
			send_byte(($urandom_range(0, 3) != 0) ? ChrLBrk : ChrO);
			if ($urandom_range(0, 4) < 3) begin
				send_byte(8'(ChrZero + $urandom_range(1, 8)));
			end else begin
				n = $urandom_range(1, 4);
				repeat (n) send_byte(8'(ChrZero + $urandom_range(0, 9)));
			end
			// skipped parameters
			if ($urandom_range(0, 9) < 3) begin
				send_byte(ChrSemi);
				n = $urandom_range(0, 3);
				repeat (n)
					send_byte(($urandom_range(0, 4) == 0) ? ChrSemi
						: 8'(ChrZero + $urandom_range(0, 9)));
			end
			n = $urandom_range(0, 9);
			if (n < 7)
				send_byte(ChrTilde);
			else if (n == 7)
				send_byte(ChrH);
			else if (n == 8)
				send_byte(ChrF);
			else
				send_byte(8'($urandom_range(0, 255)));
		end else if (pick < 88) begin
			// lone ESC, often waited out to the timeout
			eff = (pm_timeout == 8'd0) ? 1 : int'(pm_timeout);
			send_byte(ChrEsc);
			if (eff <= 16 || $urandom_range(0, 5) == 0)
				n = eff;
			else
				n = $urandom_range(1, 4);
			if ($urandom_range(0, 3) == 0)
				n = $urandom_range(1, 4);
			repeat (n) send_item(KindTick, 8'($urandom_range(0, 255)));
		end else begin
			send_byte(ChrEsc);
			send_byte(($urandom_range(0, 3) == 0) ? ChrEsc : 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic note_mismatch(input string what, input key_t want, input key_t got);
		mismatches++;
		if (mismatches <= MaxReported)
			$display("%0t: %s: expected named=%0d value=%0d, got named=%0d value=%0d",
				$realtime, what, want.named, want.value, got.named, got.value);
	endtask

	// Receiver stall pattern, re-chosen at random
	always @(posedge clk) begin
		rx_cycle++;
		if (rx_cycle % 50 == 0)
			rx_mode = rx_mode_e'($urandom_range(0, 3));
		case (rx_mode)
			RxOpen:  key_ch.ready <= 1'b1;
			RxCoin:  key_ch.ready <= 1'($urandom_range(0, 1));
			RxComb:  key_ch.ready <= (rx_cycle % 4 != 0);
			default: key_ch.ready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	// Key checker
	always @(posedge clk) begin
		if (arst_n && key_ch.valid && key_ch.ready) begin
			got_key = '{key_ch.key_named, key_ch.key_value};
			keys_seen++;
			if (got_key.named)
				named_seen++;
			if (key_q.size() == 0) begin
				note_mismatch("key with none pending", '0, got_key);
			end else begin
				want_key = key_q.pop_front();
				if (got_key.named !== want_key.named || got_key.value !== want_key.value)
					note_mismatch("key mismatch", want_key, got_key);
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (key_ch.valid && key_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("%0t: no transfer for %0d cycles, %0d keys pending",
				$realtime, idle_cycles, key_q.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [7:0] settings [5];
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		item_ch.valid     = 1'b0;
		item_ch.kind      = KindByte;
		item_ch.data_byte = '0;
		key_ch.ready      = 1'b0;
		rx_mode           = RxOpen;
		pm_mode           = ModeIdle;
		pm_ticks          = '0;
		pm_code           = '0;
		pm_timeout        = EscTimeoutReset;

		dir_rows = '{
			'{KindByte, 8'hFF,    1'b1, '{1'b0, 8'hFF}},
			'{KindTick, 8'h00,    1'b0, '0},
			'{KindByte, ChrNul,   1'b0, '0},
			'{KindByte, ScHome,   1'b1, '{1'b1, KeyHome}},
			'{KindByte, ChrNul,   1'b0, '0},
			'{KindByte, 8'h00,    1'b1, '{1'b0, 8'h00}},
			'{KindByte, ChrNul,   1'b0, '0},
			'{KindByte, ScDel,    1'b1, '{1'b1, KeyDel}},
			'{KindByte, ChrEsc,   1'b0, '0},
			'{KindByte, ChrLBrk,  1'b0, '0},
			'{KindByte, ChrA,     1'b1, '{1'b1, KeyUp}},
			'{KindByte, ChrEsc,   1'b0, '0},
			'{KindByte, ChrO,     1'b0, '0},
			'{KindByte, ChrF,     1'b1, '{1'b1, KeyEnd}},
			// saturating code, parameter, '~' with unknown code
			'{KindByte, ChrEsc,   1'b0, '0},
			'{KindByte, ChrLBrk,  1'b0, '0},
			'{KindByte, ChrNine,  1'b0, '0},
			'{KindByte, ChrNine,  1'b0, '0},
			'{KindByte, ChrNine,  1'b0, '0},
			'{KindByte, ChrSemi,  1'b0, '0},
			'{KindByte, ChrTilde, 1'b1, '{1'b0, ChrTilde}},
			// lone ESC times out after the reset count of ticks
			'{KindByte, ChrEsc,   1'b0, '0},
			'{KindTick, 8'hA5,    1'b0, '0},
			'{KindTick, 8'h5A,    1'b1, '{1'b0, ChrEsc}}
		};
		settings = '{8'd1, 8'd255, 8'd0, 8'($urandom_range(4, 254)), 8'd3};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].kind, dir_rows[i].data, dir_rows[i].typed,
				dir_rows[i].key);
		item_ch.valid <= 1'b0;

		foreach (settings[s]) begin
			write_timeout(settings[s]);
			while (fed_items < (s + 1) * PhaseItems + dir_rows.size())
				play_sequence();
			item_ch.valid <= 1'b0;
		end

		while (key_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Decoded %0d items over 6 ESC timeout settings (0, 1, 2, 3, 255 and one random).",
			fed_items);
		$display("Checked %0d keys: %0d named, %0d lone ESC timeouts; %0d mismatches.",
			keys_seen, named_seen, esc_timeouts, mismatches);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[files.f]
src/tked_pkg.sv
src/tked_item_if.sv
src/tked_key_if.sv
src/tked_decode.sv
src/terminal_key_escape_decoder.sv
tb/sv/terminal_key_escape_decoder_tb.sv
